@@ hdl/rrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the IPv4 range relate-and-split block
// Address type, relation and split-kind codes, queue word and result word.
// ----------------------------------------------------------------------------
package rrs_pkg;

   localparam int ADDR_W = 32;
   localparam int QUEUE_DEPTH = 4;

   typedef logic [ADDR_W-1:0] addr_type;

   localparam addr_type ADDR_MIN = 32'h0000_0000;
   localparam addr_type ADDR_MAX = 32'hFFFF_FFFF;

   // op codes
   localparam logic OP_CUT  = 1'b0;
   localparam logic OP_COMP = 1'b1;

   // relation of A to B
   typedef enum logic [2:0] {
      REL_EQ        = 3'd0,
      REL_INSIDE    = 3'd1,
      REL_ENCLOSES  = 3'd2,
      REL_OVL_BELOW = 3'd3,
      REL_BELOW     = 3'd4,
      REL_OVL_ABOVE = 3'd5,
      REL_ABOVE     = 3'd6,
      REL_ERROR     = 3'd7
   } rel_type;

   // how the back end builds the ranges
   typedef enum logic [3:0] {
      KIND_OVL_BELOW  = 4'd0,
      KIND_OVL_ABOVE  = 4'd1,
      KIND_IN_START   = 4'd2,
      KIND_IN_END     = 4'd3,
      KIND_IN_STRICT  = 4'd4,
      KIND_ENC_START  = 4'd5,
      KIND_ENC_END    = 4'd6,
      KIND_ENC_STRICT = 4'd7,
      KIND_REFUSE     = 4'd8,
      KIND_COMP_BOTH  = 4'd9,
      KIND_COMP_UPPER = 4'd10,
      KIND_COMP_LOWER = 4'd11,
      KIND_COMP_WHOLE = 4'd12
   } kind_type;

   // classified word held in the queue
   typedef struct packed {
      rel_type  relation;
      kind_type kind;
      addr_type a_low;
      addr_type a_high;
      addr_type b_low;
      addr_type b_high;
   } item_type;

   // result word
   typedef struct packed {
      rel_type  relation;
      logic     failed;
      addr_type first_low;
      addr_type first_high;
      logic     second_valid;
      addr_type second_low;
      addr_type second_high;
      logic     third_valid;
      addr_type third_low;
      addr_type third_high;
   } result_type;

endpackage

@@ hdl/rrs_front.sv @@
// ----------------------------------------------------------------------------
// rrs_front: classifier
// Compares range A against range B, picks the relation and the split kind,
// and writes the classified word into the queue.
// ----------------------------------------------------------------------------
module rrs_front (
   input  logic              req_push,
   input  logic              q_full,
   input  logic              req_op,
   input  rrs_pkg::addr_type req_a_low,
   input  rrs_pkg::addr_type req_a_high,
   input  rrs_pkg::addr_type req_b_low,
   input  rrs_pkg::addr_type req_b_high,
   output logic              q_wr,
   output rrs_pkg::item_type q_item
);
   import rrs_pkg::*;

   rel_type  rel;
   kind_type kind;
   logic     same_low;
   logic     same_high;

   assign same_low  = (req_a_low == req_b_low);
   assign same_high = (req_a_high == req_b_high);

   // relation, first matching rule wins
   always_comb begin
      if (same_low && same_high) begin
         rel = REL_EQ;
      end else if (req_a_low >= req_b_low && req_a_low <= req_b_high &&
                   req_a_high <= req_b_high) begin
         rel = REL_INSIDE;
      end else if (req_a_low <= req_b_low && req_a_high >= req_b_high) begin
         rel = REL_ENCLOSES;
      end else if (req_a_low < req_b_low && req_a_high < req_b_high &&
                   req_a_high >= req_b_low) begin
         rel = REL_OVL_BELOW;
      end else if (req_a_low < req_b_low && req_a_high < req_b_high) begin
         rel = REL_BELOW;
      end else if (req_a_low > req_b_low && req_a_low <= req_b_high &&
                   req_a_high > req_b_high) begin
         rel = REL_OVL_ABOVE;
      end else if (req_a_low > req_b_high) begin
         rel = REL_ABOVE;
      end else begin
         rel = REL_ERROR;
      end
   end

   // split kind from op, relation and shared edges
   always_comb begin
      if (req_op == OP_COMP) begin
         if (req_a_low != ADDR_MIN && req_a_high != ADDR_MAX) begin
            kind = KIND_COMP_BOTH;
         end else if (req_a_low == ADDR_MIN && req_a_high != ADDR_MAX) begin
            kind = KIND_COMP_UPPER;
         end else if (req_a_low != ADDR_MIN) begin
            kind = KIND_COMP_LOWER;
         end else begin
            kind = KIND_COMP_WHOLE;
         end
      end else begin
         unique case (rel)
            REL_OVL_BELOW: kind = KIND_OVL_BELOW;
            REL_OVL_ABOVE: kind = KIND_OVL_ABOVE;
            REL_INSIDE: begin
               if (same_low)       kind = KIND_IN_START;
               else if (same_high) kind = KIND_IN_END;
               else                kind = KIND_IN_STRICT;
            end
            REL_ENCLOSES: begin
               if (same_low)       kind = KIND_ENC_START;
               else if (same_high) kind = KIND_ENC_END;
               else                kind = KIND_ENC_STRICT;
            end
            default: kind = KIND_REFUSE;
         endcase
      end
   end

   assign q_wr            = req_push && !q_full;
   assign q_item.relation = rel;
   assign q_item.kind     = kind;
   assign q_item.a_low    = req_a_low;
   assign q_item.a_high   = req_a_high;
   assign q_item.b_low    = req_b_low;
   assign q_item.b_high   = req_b_high;

endmodule

@@ hdl/rrs_queue.sv @@
// ----------------------------------------------------------------------------
// rrs_queue: classified-word queue
// Short first-in first-out buffer between classifier and splitter, so each
// side stalls on its own. Head word is shown while not empty.
// ----------------------------------------------------------------------------
module rrs_queue #(
   parameter int Depth = rrs_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  rrs_pkg::item_type wr_item,
   output logic              full,
   input  logic              rd,
   output logic              empty,
   output rrs_pkg::item_type rd_item
);
   import rrs_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            entries_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_wr, do_rd;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr && !full;
   assign do_rd   = rd && !empty;
   assign rd_item = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

   // a lone write grows the count by one
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on write");

   // a lone read shrinks the count by one
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (do_rd && !do_wr) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink on read");

endmodule

@@ hdl/rrs_back.sv @@
// ----------------------------------------------------------------------------
// rrs_back: splitter and result register
// Takes the queue head, forms the range edges and the result word, and holds
// it in the output register until popped.
// ----------------------------------------------------------------------------
module rrs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  rrs_pkg::item_type   q_item,
   output logic                q_rd,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output rrs_pkg::result_type rsp_word
);
   import rrs_pkg::*;

   addr_type   al, ah, bl, bh;
   addr_type   al_m1, ah_p1, bl_m1, bh_p1;
   result_type res_in, res_ff;
   logic       valid_ff, valid_in;
   logic       take;

   assign al = q_item.a_low;
   assign ah = q_item.a_high;
   assign bl = q_item.b_low;
   assign bh = q_item.b_high;

   // edge neighbors, wrap modulo 2^32
   assign al_m1 = al - 1'b1;
   assign ah_p1 = ah + 1'b1;
   assign bl_m1 = bl - 1'b1;
   assign bh_p1 = bh + 1'b1;

   // result word from split kind
   always_comb begin
      res_in          = '0;
      res_in.relation = q_item.relation;
      unique case (q_item.kind)
         KIND_OVL_BELOW: begin
            res_in.first_low  = al;    res_in.first_high  = bl_m1;
            res_in.second_low = bl;    res_in.second_high = ah;
            res_in.third_low  = ah_p1; res_in.third_high  = bh;
            res_in.second_valid = 1'b1; res_in.third_valid = 1'b1;
         end
         KIND_OVL_ABOVE: begin
            res_in.first_low  = bl;    res_in.first_high  = al_m1;
            res_in.second_low = al;    res_in.second_high = bh;
            res_in.third_low  = bh_p1; res_in.third_high  = ah;
            res_in.second_valid = 1'b1; res_in.third_valid = 1'b1;
         end
         KIND_IN_START: begin
            res_in.first_low  = al;    res_in.first_high  = ah;
            res_in.second_low = ah_p1; res_in.second_high = bh;
            res_in.second_valid = 1'b1;
         end
         KIND_IN_END: begin
            res_in.first_low  = bl;    res_in.first_high  = al_m1;
            res_in.second_low = al;    res_in.second_high = ah;
            res_in.second_valid = 1'b1;
         end
         KIND_IN_STRICT: begin
            res_in.first_low  = bl;    res_in.first_high  = al_m1;
            res_in.second_low = al;    res_in.second_high = ah;
            res_in.third_low  = ah_p1; res_in.third_high  = bh;
            res_in.second_valid = 1'b1; res_in.third_valid = 1'b1;
         end
         KIND_ENC_START: begin
            res_in.first_low  = bl;    res_in.first_high  = bh;
            res_in.second_low = bh_p1; res_in.second_high = ah;
            res_in.second_valid = 1'b1;
         end
         KIND_ENC_END: begin
            res_in.first_low  = al;    res_in.first_high  = bl_m1;
            res_in.second_low = bl;    res_in.second_high = bh;
            res_in.second_valid = 1'b1;
         end
         KIND_ENC_STRICT: begin
            res_in.first_low  = al;    res_in.first_high  = bl_m1;
            res_in.second_low = bl;    res_in.second_high = bh;
            res_in.third_low  = bh_p1; res_in.third_high  = ah;
            res_in.second_valid = 1'b1; res_in.third_valid = 1'b1;
         end
         KIND_REFUSE: begin
            // cut refused: echo A and B
            res_in.failed     = 1'b1;
            res_in.first_low  = al;    res_in.first_high  = ah;
            res_in.second_low = bl;    res_in.second_high = bh;
            res_in.second_valid = 1'b1;
         end
         KIND_COMP_BOTH: begin
            res_in.first_low  = ADDR_MIN; res_in.first_high  = al_m1;
            res_in.second_low = ah_p1;    res_in.second_high = ADDR_MAX;
            res_in.second_valid = 1'b1;
         end
         KIND_COMP_UPPER: begin
            res_in.first_low  = ah_p1;    res_in.first_high  = ADDR_MAX;
         end
         KIND_COMP_LOWER: begin
            res_in.first_low  = ADDR_MIN; res_in.first_high  = al_m1;
         end
         KIND_COMP_WHOLE: begin
            res_in.failed     = 1'b1;
            res_in.first_low  = al;       res_in.first_high  = ah;
         end
         default: begin
            res_in.failed = 1'b1;
         end
      endcase
   end

   // load when the slot is free or being drained
   assign take = !q_empty && (!valid_ff || rsp_pop);
   assign q_rd = take;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff <= res_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_word  = res_ff;

   // a third range never comes without a second
   a_third_needs_second: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.third_valid) |-> res_ff.second_valid)
      else $error("third range without second");

   // absent ranges read as zero
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !res_ff.second_valid) |->
         (res_ff.second_low == '0 && res_ff.second_high == '0))
      else $error("absent second range not zero");

   // a queued word moves into a free slot on the next edge
   a_slot_fill: assert property (@(posedge clock) disable iff (reset)
      (!q_empty && !valid_ff) |=> valid_ff)
      else $error("free result slot not filled");

endmodule

@@ hdl/ipv4_range_relate_and_split_top.sv @@
// ----------------------------------------------------------------------------
// ipv4_range_relate_and_split_top: IPv4 range relate-and-split block
// Classifier, queue and splitter joined behind queue-style ports.
// ----------------------------------------------------------------------------
// Takes one word per cycle while full is low: two inclusive IPv4 ranges and
// an op (cut or complement), and returns one result word per input word, in
// order. The classifier works in the cycle of the push and writes the queue;
// the splitter loads the result register from the queue head, so each result
// passes through the queue before it shows, and one word leaves per cycle
// while pop stays high. The queue (QueueDepth words, default four) lets the
// push side run on while results wait; full rises only when it is filled.
module ipv4_range_relate_and_split_top #(
   parameter int QueueDepth = rrs_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_op,
   input  rrs_pkg::addr_type req_a_low,
   input  rrs_pkg::addr_type req_a_high,
   input  rrs_pkg::addr_type req_b_low,
   input  rrs_pkg::addr_type req_b_high,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [2:0]        rsp_relation,
   output logic              rsp_failed,
   output rrs_pkg::addr_type rsp_first_low,
   output rrs_pkg::addr_type rsp_first_high,
   output logic              rsp_second_valid,
   output rrs_pkg::addr_type rsp_second_low,
   output rrs_pkg::addr_type rsp_second_high,
   output logic              rsp_third_valid,
   output rrs_pkg::addr_type rsp_third_low,
   output rrs_pkg::addr_type rsp_third_high
);
   import rrs_pkg::*;

   logic       q_wr, q_rd, q_full, q_empty;
   item_type   wr_item, rd_item;
   result_type rsp_word;

   rrs_front u_front (
      .req_push   (req_push),
      .q_full     (q_full),
      .req_op     (req_op),
      .req_a_low  (req_a_low),
      .req_a_high (req_a_high),
      .req_b_low  (req_b_low),
      .req_b_high (req_b_high),
      .q_wr       (q_wr),
      .q_item     (wr_item)
   );

   rrs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_item (wr_item),
      .full    (q_full),
      .rd      (q_rd),
      .empty   (q_empty),
      .rd_item (rd_item)
   );

   rrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (rd_item),
      .q_rd      (q_rd),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word)
   );

   // result word onto ports
   assign req_full         = q_full;
   assign rsp_relation     = rsp_word.relation;
   assign rsp_failed       = rsp_word.failed;
   assign rsp_first_low    = rsp_word.first_low;
   assign rsp_first_high   = rsp_word.first_high;
   assign rsp_second_valid = rsp_word.second_valid;
   assign rsp_second_low   = rsp_word.second_low;
   assign rsp_second_high  = rsp_word.second_high;
   assign rsp_third_valid  = rsp_word.third_valid;
   assign rsp_third_low    = rsp_word.third_low;
   assign rsp_third_high   = rsp_word.third_high;

endmodule

@@ test/tb_ipv4_range_relate_and_split_top.sv @@
// ----------------------------------------------------------------------------
// tb_ipv4_range_relate_and_split_top: self-checking bench for the range block
// Drives range pairs through the push side and pops result words at random.
// A local split model predicts every word and a monitor compares each popped
// word field by field, in order. Directed cases come first, then clustered
// random pairs under three idling mixes, with a drain pause in between.
// ----------------------------------------------------------------------------
module tb_ipv4_range_relate_and_split_top;
   import rrs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int END_CYCLES  = 10;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic       req_op;
   addr_type   req_a_low;
   addr_type   req_a_high;
   addr_type   req_b_low;
   addr_type   req_b_high;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [2:0] rsp_relation;
   logic       rsp_failed;
   addr_type   rsp_first_low;
   addr_type   rsp_first_high;
   logic       rsp_second_valid;
   addr_type   rsp_second_low;
   addr_type   rsp_second_high;
   logic       rsp_third_valid;
   addr_type   rsp_third_low;
   addr_type   rsp_third_high;

   // predicted words, oldest first
   result_type pending_results[$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         send_idle = 0;
   int         recv_idle = 0;

   ipv4_range_relate_and_split_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op           (req_op),
      .req_a_low        (req_a_low),
      .req_a_high       (req_a_high),
      .req_b_low        (req_b_low),
      .req_b_high       (req_b_high),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_relation     (rsp_relation),
      .rsp_failed       (rsp_failed),
      .rsp_first_low    (rsp_first_low),
      .rsp_first_high   (rsp_first_high),
      .rsp_second_valid (rsp_second_valid),
      .rsp_second_low   (rsp_second_low),
      .rsp_second_high  (rsp_second_high),
      .rsp_third_valid  (rsp_third_valid),
      .rsp_third_low    (rsp_third_low),
      .rsp_third_high   (rsp_third_high)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // relation of A to B, then the ranges that op makes of it
   function automatic result_type split_ranges(input logic op, input addr_type al,
                                               input addr_type ah, input addr_type bl,
                                               input addr_type bh);
      result_type r;
      rel_type    rel;
      r = '0;
      if (al == bl && ah == bh) rel = REL_EQ;
      else if (al >= bl && al <= bh && ah <= bh) rel = REL_INSIDE;
      else if (al <= bl && ah >= bh) rel = REL_ENCLOSES;
      else if (al < bl && ah < bh && ah >= bl) rel = REL_OVL_BELOW;
      else if (al < bl && ah < bh) rel = REL_BELOW;
      else if (al > bl && al <= bh && ah > bh) rel = REL_OVL_ABOVE;
      else if (al > bh) rel = REL_ABOVE;
      else rel = REL_ERROR;
      r.relation = rel;

      if (op == OP_CUT) begin
         r.second_valid = 1'b1;
         r.third_valid  = 1'b1;
         case (rel)
            REL_OVL_BELOW: begin
               {r.first_low, r.first_high, r.second_low, r.second_high,
                r.third_low, r.third_high} = {al, bl - 32'd1, bl, ah, ah + 32'd1, bh};
            end
            REL_OVL_ABOVE: begin
               {r.first_low, r.first_high, r.second_low, r.second_high,
                r.third_low, r.third_high} = {bl, al - 32'd1, al, bh, bh + 32'd1, ah};
            end
            REL_INSIDE: begin
               if (al == bl) begin
                  {r.first_low, r.first_high, r.second_low, r.second_high} =
                     {al, ah, ah + 32'd1, bh};
                  r.third_valid = 1'b0;
               end else if (ah == bh) begin
                  {r.first_low, r.first_high, r.second_low, r.second_high} =
                     {bl, al - 32'd1, al, ah};
                  r.third_valid = 1'b0;
               end else begin
                  {r.first_low, r.first_high, r.second_low, r.second_high,
                   r.third_low, r.third_high} = {bl, al - 32'd1, al, ah, ah + 32'd1, bh};
               end
            end
            REL_ENCLOSES: begin
               if (al == bl) begin
                  {r.first_low, r.first_high, r.second_low, r.second_high} =
                     {bl, bh, bh + 32'd1, ah};
                  r.third_valid = 1'b0;
               end else if (ah == bh) begin
                  {r.first_low, r.first_high, r.second_low, r.second_high} =
                     {al, bl - 32'd1, bl, bh};
                  r.third_valid = 1'b0;
               end else begin
                  {r.first_low, r.first_high, r.second_low, r.second_high,
                   r.third_low, r.third_high} = {al, bl - 32'd1, bl, bh, bh + 32'd1, ah};
               end
            end
            default: begin
               // no split: echo both ranges
               r.failed      = 1'b1;
               r.third_valid = 1'b0;
               {r.first_low, r.first_high, r.second_low, r.second_high} = {al, ah, bl, bh};
            end
         endcase
      end else begin
         if (al != ADDR_MIN && ah != ADDR_MAX) begin
            r.second_valid = 1'b1;
            {r.first_low, r.first_high, r.second_low, r.second_high} =
               {ADDR_MIN, al - 32'd1, ah + 32'd1, ADDR_MAX};
         end else if (al == ADDR_MIN && ah != ADDR_MAX) begin
            {r.first_low, r.first_high} = {ah + 32'd1, ADDR_MAX};
         end else if (al != ADDR_MIN) begin
            {r.first_low, r.first_high} = {ADDR_MIN, al - 32'd1};
         end else begin
            // whole address space has no outside
            r.failed = 1'b1;
            {r.first_low, r.first_high} = {al, ah};
         end
      end
      return r;
   endfunction

   // send one word; called right after a rising edge, returns at its accepting edge
   task automatic push_ranges(input logic op, input addr_type al, input addr_type ah,
                              input addr_type bl, input addr_type bh);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push   <= 1'b1;
      req_op     <= op;
      req_a_low  <= al;
      req_a_high <= ah;
      req_b_low  <= bl;
      req_b_high <= bh;
      forever begin
         @(negedge clock);
         if (!req_full) break;
         @(posedge clock);
      end
      @(posedge clock);
      pending_results.push_back(split_ranges(op, al, ah, bl, bh));
   endtask

   // hold the push side until every predicted word has been popped
   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_cut_splits();
      push_ranges(OP_CUT, 32'd10, 32'd15, 32'd10, 32'd20);   // inside, same start
      push_ranges(OP_CUT, 32'd15, 32'd20, 32'd10, 32'd20);   // inside, same end
      push_ranges(OP_CUT, 32'd12, 32'd15, 32'd10, 32'd20);   // inside, strict
      push_ranges(OP_CUT, 32'd10, 32'd30, 32'd10, 32'd20);   // encloses, same start
      push_ranges(OP_CUT, 32'd5,  32'd20, 32'd10, 32'd20);   // encloses, same end
      push_ranges(OP_CUT, 32'd5,  32'd30, 32'd10, 32'd20);   // encloses, strict
      push_ranges(OP_CUT, 32'd5,  32'd15, 32'd10, 32'd20);   // overlap below
      push_ranges(OP_CUT, 32'd15, 32'd25, 32'd10, 32'd20);   // overlap above
      push_ranges(OP_CUT, 32'd1, ADDR_MAX - 32'd1, ADDR_MIN, ADDR_MAX);
      push_ranges(OP_CUT, ADDR_MIN, ADDR_MAX - 32'd1, 32'd1, ADDR_MAX);
      push_ranges(OP_CUT, 32'd1, ADDR_MAX, ADDR_MIN, ADDR_MAX - 32'd1);
      // low above high: still classified and split
      push_ranges(OP_CUT, 32'd20, 32'd5, 32'd10, 32'd30);
      push_ranges(OP_CUT, 32'd5, ADDR_MAX, 32'd5, 32'd3);
   endtask

   // equal, below and above are refused; the error code cannot be produced,
   // since the rules before it cover every pair
   task automatic test_cut_refused();
      push_ranges(OP_CUT, 32'd10, 32'd20, 32'd10, 32'd20);
      push_ranges(OP_CUT, ADDR_MIN, ADDR_MAX, ADDR_MIN, ADDR_MAX);
      push_ranges(OP_CUT, ADDR_MIN, ADDR_MIN, 32'd1, 32'd1);
      push_ranges(OP_CUT, ADDR_MAX, ADDR_MAX, ADDR_MIN, ADDR_MIN);
      push_ranges(OP_CUT, 32'd1, 32'd5, 32'd10, 32'd20);
   endtask

   task automatic test_complement();
      push_ranges(OP_COMP, 32'd10, 32'd20, $urandom, $urandom);
      push_ranges(OP_COMP, ADDR_MIN, 32'd20, $urandom, $urandom);
      push_ranges(OP_COMP, 32'd10, ADDR_MAX, $urandom, $urandom);
      push_ranges(OP_COMP, ADDR_MIN, ADDR_MAX, $urandom, $urandom);
      push_ranges(OP_COMP, ADDR_MIN, ADDR_MIN, ADDR_MAX, ADDR_MAX);
      push_ranges(OP_COMP, ADDR_MAX, ADDR_MAX, ADDR_MIN, ADDR_MIN);
      push_ranges(OP_COMP, ADDR_MAX, ADDR_MIN, $urandom, $urandom);
   endtask

   // addresses clustered near a base so ends often touch or coincide
   function automatic addr_type near_addr(input addr_type base);
      case ($urandom_range(15))
         0:       return ADDR_MIN;
         1:       return ADDR_MAX;
         2, 3:    return $urandom;
         default: return base + addr_type'($urandom_range(16)) - 32'd8;
      endcase
   endfunction

   task automatic test_random_ranges(input int count);
      addr_type base;
      addr_type x [4];
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0:       base = 32'd8;
            1:       base = ADDR_MAX - 32'd8;
            default: base = $urandom;
         endcase
         foreach (x[k]) x[k] = near_addr(base);
         if ($urandom_range(99) < 85) begin
            // well-formed ranges
            if (x[0] > x[1]) {x[0], x[1]} = {x[1], x[0]};
            if (x[2] > x[3]) {x[2], x[3]} = {x[3], x[2]};
         end
         push_ranges(1'($urandom_range(1)), x[0], x[1], x[2], x[3]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: pop with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor: the handshakes seen at the falling edge complete at the next rise
   always @(negedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_pop && !rsp_empty) begin
            got.relation     = rel_type'(rsp_relation);
            got.failed       = rsp_failed;
            got.first_low    = rsp_first_low;
            got.first_high   = rsp_first_high;
            got.second_valid = rsp_second_valid;
            got.second_low   = rsp_second_low;
            got.second_high  = rsp_second_high;
            got.third_valid  = rsp_third_valid;
            got.third_low    = rsp_third_low;
            got.third_high   = rsp_third_high;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected word, expected none actual %h", $time, got);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("relation", 32'(want.relation), 32'(got.relation));
               check_field("failed", 32'(want.failed), 32'(got.failed));
               check_field("first_low", want.first_low, got.first_low);
               check_field("first_high", want.first_high, got.first_high);
               check_field("second_valid", 32'(want.second_valid),
                           32'(got.second_valid));
               check_field("second_low", want.second_low, got.second_low);
               check_field("second_high", want.second_high, got.second_high);
               check_field("third_valid", 32'(want.third_valid),
                           32'(got.third_valid));
               check_field("third_low", want.third_low, got.third_low);
               check_field("third_high", want.third_high, got.third_high);
            end
         end
      end
   end

   // watchdog: too long without any handshake
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(negedge clock);
      $display("tb_ipv4_range_relate_and_split_top: errors");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_push   = 1'b0;
      req_op     = OP_CUT;
      req_a_low  = '0;
      req_a_high = '0;
      req_b_low  = '0;
      req_b_high = '0;
      send_idle  = 36;
      recv_idle  = 68;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_cut_splits();
      test_cut_refused();
      test_complement();
      wait_for_drain();
      test_random_ranges(270);
      wait_for_drain();

      send_idle = 68;
      recv_idle = 36;
      test_random_ranges(270);
      wait_for_drain();

      send_idle = 0;
      recv_idle = 0;
      test_random_ranges(260);
      wait_for_drain();

      // let any stray word show up
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb_ipv4_range_relate_and_split_top: clean");
      end else begin
         $display("tb_ipv4_range_relate_and_split_top: errors");
      end
      $finish;
   end

endmodule

@@ ipv4_range_relate_and_split_top.f @@
hdl/rrs_pkg.sv
hdl/rrs_front.sv
hdl/rrs_queue.sv
hdl/rrs_back.sv
hdl/ipv4_range_relate_and_split_top.sv
test/tb_ipv4_range_relate_and_split_top.sv
